[design/tlc_pkg.sv]
// Shared types, sizes and codes for the three-level cache lookup core.
// Used by tlc_stats, three_level_cache_lookup_lfu_core and the testbench.
`default_nettype none
package tlc_pkg;

	localparam int L1_LINES  = 8;
	localparam int L2_LINES  = 16;
	localparam int L3_LINES  = 32;
	localparam int ADDR_BITS = 10;
	localparam int USE_BITS  = 16;
	localparam int COST_BITS = 18;
	localparam int CNT_BITS  = 32;
	localparam int L1_AW     = $clog2(L1_LINES);
	localparam int L2_AW     = $clog2(L2_LINES);
	localparam int L3_AW     = $clog2(L3_LINES);
	localparam int IDX_W     = L3_AW;

	// hit level codes
	localparam logic [1:0] LVL_L1  = 2'd0;
	localparam logic [1:0] LVL_L2  = 2'd1;
	localparam logic [1:0] LVL_L3  = 2'd2;
	localparam logic [1:0] LVL_MEM = 2'd3;

	// register indexes
	localparam logic [2:0] REG_LFU   = 3'd0;
	localparam logic [2:0] REG_COST1 = 3'd1;
	localparam logic [2:0] REG_COST2 = 3'd2;
	localparam logic [2:0] REG_COST3 = 3'd3;
	localparam logic [2:0] REG_COSTM = 3'd4;

	// one stored line, valid bit kept apart in flops
	typedef struct packed {
		logic [ADDR_BITS-1:0] tag;
		logic                 dirty;
		logic [USE_BITS-1:0]  uses;
	} line_t;

	localparam int LINE_W = $bits(line_t);

	// finished item handed to the statistics unit
	typedef struct packed {
		logic                 en;
		logic [1:0]           level;
		logic [COST_BITS-1:0] cost;
		logic                 wb_valid;
		logic [ADDR_BITS-1:0] wb_block;
	} commit_t;

endpackage
`default_nettype wire

[design/three_level_cache_lookup_lfu_core.sv]
// Three-level fully associative cache lookup with LFU victims (line 0 when LFU is off): sequencer top level.
// Depends on tlc_pkg, tlc_ram, tlc_stats.
// Each level searched takes one RAM read per line, then a drain step and a decide step.
// Throughput: one item at a time; busy stays high until the item commits.
// Reset: arst_n clears valid bits, counters, total cost and registers to reset values.
// Results cannot be stalled: done marks each item for one cycle.
`default_nettype none
module three_level_cache_lookup_lfu_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [tlc_pkg::ADDR_BITS-1:0]      block_address,
	input  wire logic                               write_access,
	output logic                                    done,
	output logic [1:0]                              hit_level,
	output logic [tlc_pkg::COST_BITS-1:0]           access_cost,
	output logic                                    writeback_valid,
	output logic [tlc_pkg::ADDR_BITS-1:0]           writeback_block,
	output logic [tlc_pkg::CNT_BITS-1:0]            total_cost,
	output logic [tlc_pkg::CNT_BITS-1:0]            level_one_hits,
	output logic [tlc_pkg::CNT_BITS-1:0]            level_two_hits,
	output logic [tlc_pkg::CNT_BITS-1:0]            level_three_hits,
	output logic [tlc_pkg::CNT_BITS-1:0]            memory_accesses,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [4:0]                         paddr,
	input  wire logic [31:0]                        pwdata,
	output logic [31:0]                             prdata,
	output logic                                    pready
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DRAIN  = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_FILL   = 3'd4;

	localparam int IW = tlc_pkg::IDX_W;

	// configuration registers
	logic        lfu_q;
	logic [15:0] c1_q, c2_q, c3_q, cm_q;
	logic [2:0]  reg_idx;
	logic        cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfu_q <= 1'b1;
			c1_q  <= 16'd1;
			c2_q  <= 16'd10;
			c3_q  <= 16'd100;
			cm_q  <= 16'd1000;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				tlc_pkg::REG_LFU:   lfu_q <= pwdata[0];
				tlc_pkg::REG_COST1: c1_q  <= pwdata[15:0];
				tlc_pkg::REG_COST2: c2_q  <= pwdata[15:0];
				tlc_pkg::REG_COST3: c3_q  <= pwdata[15:0];
				tlc_pkg::REG_COSTM: cm_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			tlc_pkg::REG_LFU:   prdata = {31'd0, lfu_q};
			tlc_pkg::REG_COST1: prdata = {16'd0, c1_q};
			tlc_pkg::REG_COST2: prdata = {16'd0, c2_q};
			tlc_pkg::REG_COST3: prdata = {16'd0, c3_q};
			tlc_pkg::REG_COSTM: prdata = {16'd0, cm_q};
			default:            prdata = 32'd0;
		endcase
	end

	// sequencer state
	logic [2:0]                      state_q;
	logic [1:0]                      lvl_q;
	logic [IW-1:0]                   idx_q;
	logic [tlc_pkg::ADDR_BITS-1:0]   addr_q;
	logic                            wr_q;
	logic [tlc_pkg::COST_BITS-1:0]   cost_q;
	logic                            rd_vld_s1;
	logic [IW-1:0]                   rd_idx_s1;
	logic                            hit_q;
	logic [IW-1:0]                   hit_idx_q;
	tlc_pkg::line_t                  hit_line_q;
	logic [IW-1:0]                   min_idx_q;
	tlc_pkg::line_t                  min_line_q;
	tlc_pkg::line_t                  zero_line_q;
	logic [IW-1:0]                   vic_idx_q [3];
	tlc_pkg::line_t                  vic_line_q [3];
	logic [2:0]                      vic_vd_q;

	// valid bits
	logic [tlc_pkg::L1_LINES-1:0] v1_q;
	logic [tlc_pkg::L2_LINES-1:0] v2_q;
	logic [tlc_pkg::L3_LINES-1:0] v3_q;

	// RAM ports
	logic [tlc_pkg::LINE_W-1:0] rd1, rd2, rd3;
	logic                       we1, we2, we3;
	logic [tlc_pkg::L1_AW-1:0]  wa1;
	logic [tlc_pkg::L2_AW-1:0]  wa2;
	logic [tlc_pkg::L3_AW-1:0]  wa3;
	tlc_pkg::line_t             wd1, wd2, wd3;
	logic                       rd_en;

	assign rd_en = (state_q == ST_SCAN);

	tlc_ram #(.DEPTH(tlc_pkg::L1_LINES), .WIDTH(tlc_pkg::LINE_W)) u_ram1 (
		.clk(clk), .we(we1), .waddr(wa1), .wdata(wd1),
		.re(rd_en && lvl_q == tlc_pkg::LVL_L1), .raddr(idx_q[tlc_pkg::L1_AW-1:0]),
		.rdata(rd1));
	tlc_ram #(.DEPTH(tlc_pkg::L2_LINES), .WIDTH(tlc_pkg::LINE_W)) u_ram2 (
		.clk(clk), .we(we2), .waddr(wa2), .wdata(wd2),
		.re(rd_en && lvl_q == tlc_pkg::LVL_L2), .raddr(idx_q[tlc_pkg::L2_AW-1:0]),
		.rdata(rd2));
	tlc_ram #(.DEPTH(tlc_pkg::L3_LINES), .WIDTH(tlc_pkg::LINE_W)) u_ram3 (
		.clk(clk), .we(we3), .waddr(wa3), .wdata(wd3),
		.re(rd_en && lvl_q == tlc_pkg::LVL_L3), .raddr(idx_q[tlc_pkg::L3_AW-1:0]),
		.rdata(rd3));

	// current level view: read data, valid vector, last index
	tlc_pkg::line_t          cur_line;
	logic [(1<<IW)-1:0]      cur_valid;
	logic [IW-1:0]           last_idx;

	always_comb begin
		cur_valid = '0;
		unique case (lvl_q)
			tlc_pkg::LVL_L1: begin
				cur_line = rd1;
				cur_valid[tlc_pkg::L1_LINES-1:0] = v1_q;
				last_idx = IW'(tlc_pkg::L1_LINES - 1);
			end
			tlc_pkg::LVL_L2: begin
				cur_line = rd2;
				cur_valid[tlc_pkg::L2_LINES-1:0] = v2_q;
				last_idx = IW'(tlc_pkg::L2_LINES - 1);
			end
			default: begin
				cur_line = rd3;
				cur_valid[tlc_pkg::L3_LINES-1:0] = v3_q;
				last_idx = IW'(tlc_pkg::L3_LINES - 1);
			end
		endcase
	end

	// first invalid line of the current level
	logic          any_inv;
	logic [IW-1:0] first_inv;

	always_comb begin
		any_inv   = 1'b0;
		first_inv = '0;
		for (int i = (1 << IW) - 1; i >= 0; i--) begin
			if (IW'(i) <= last_idx && !cur_valid[i]) begin
				any_inv   = 1'b1;
				first_inv = IW'(i);
			end
		end
	end

	// victim of the current level
	logic [IW-1:0]  vic_idx;
	tlc_pkg::line_t vic_line;
	logic           vic_vd;

	always_comb begin
		priority if (any_inv) begin
			vic_idx  = first_inv;
			vic_line = zero_line_q;
			vic_vd   = 1'b0;
		end else if (lfu_q) begin
			vic_idx  = min_idx_q;
			vic_line = min_line_q;
			vic_vd   = min_line_q.dirty;
		end else begin
			vic_idx  = '0;
			vic_line = zero_line_q;
			vic_vd   = zero_line_q.dirty;
		end
	end

	// touched copy of the hit line
	tlc_pkg::line_t hit_upd;

	always_comb begin
		hit_upd       = hit_line_q;
		hit_upd.dirty = hit_line_q.dirty | wr_q;
		if (hit_line_q.uses != '1) begin
			hit_upd.uses = hit_line_q.uses + 1'b1;
		end
	end

	logic hit_wr;
	logic mv1, mv2;

	assign hit_wr = (state_q == ST_DECIDE) && hit_q;
	assign mv1    = vic_vd_q[0];
	assign mv2    = vic_vd_q[0] && vic_vd_q[1];

	// RAM write port selection: hit touch or fill cascade
	always_comb begin
		we1 = 1'b0; we2 = 1'b0; we3 = 1'b0;
		wa1 = hit_idx_q[tlc_pkg::L1_AW-1:0];
		wa2 = hit_idx_q[tlc_pkg::L2_AW-1:0];
		wa3 = hit_idx_q[tlc_pkg::L3_AW-1:0];
		wd1 = hit_upd; wd2 = hit_upd; wd3 = hit_upd;
		if (hit_wr) begin
			we1 = (lvl_q == tlc_pkg::LVL_L1);
			we2 = (lvl_q == tlc_pkg::LVL_L2);
			we3 = (lvl_q == tlc_pkg::LVL_L3);
		end else if (state_q == ST_FILL) begin
			we1 = 1'b1;
			wa1 = vic_idx_q[0][tlc_pkg::L1_AW-1:0];
			wd1 = '{tag: addr_q, dirty: wr_q, uses: tlc_pkg::USE_BITS'(1)};
			we2 = mv1;
			wa2 = vic_idx_q[1][tlc_pkg::L2_AW-1:0];
			wd2 = vic_line_q[0];
			we3 = mv2;
			wa3 = vic_idx_q[2][tlc_pkg::L3_AW-1:0];
			wd3 = vic_line_q[1];
		end
	end

	// commit to statistics
	tlc_pkg::commit_t commit;

	always_comb begin
		commit          = '0;
		commit.cost     = cost_q;
		commit.wb_block = vic_line_q[2].tag;
		if (hit_wr) begin
			commit.en    = 1'b1;
			commit.level = lvl_q;
		end else if (state_q == ST_FILL) begin
			commit.en       = 1'b1;
			commit.level    = tlc_pkg::LVL_MEM;
			commit.wb_valid = mv2 && vic_vd_q[2];
		end
	end

	// next-level cost term
	logic [15:0] next_cost;

	always_comb begin
		unique case (lvl_q)
			tlc_pkg::LVL_L1: next_cost = c2_q;
			tlc_pkg::LVL_L2: next_cost = c3_q;
			default:         next_cost = cm_q;
		endcase
	end

	// control: state, level, index, valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			lvl_q     <= tlc_pkg::LVL_L1;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
			v1_q      <= '0;
			v2_q      <= '0;
			v3_q      <= '0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (rd_vld_s1 && cur_valid[rd_idx_s1] && cur_line.tag == addr_q) begin
				hit_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN;
						lvl_q   <= tlc_pkg::LVL_L1;
						idx_q   <= '0;
						hit_q   <= 1'b0;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == last_idx) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_DECIDE;
				ST_DECIDE: begin
					priority if (hit_q) begin
						state_q <= ST_IDLE;
					end else if (lvl_q == tlc_pkg::LVL_L3) begin
						state_q <= ST_FILL;
					end else begin
						state_q <= ST_SCAN;
						lvl_q   <= lvl_q + 1'b1;
						idx_q   <= '0;
					end
				end
				ST_FILL: begin
					state_q <= ST_IDLE;
					v1_q[vic_idx_q[0][tlc_pkg::L1_AW-1:0]] <= 1'b1;
					if (mv1) begin
						v2_q[vic_idx_q[1][tlc_pkg::L2_AW-1:0]] <= 1'b1;
					end
					if (mv2) begin
						v3_q[vic_idx_q[2][tlc_pkg::L3_AW-1:0]] <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// scan datapath: item, cost, hit and least-used tracking, victims
	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
		if (state_q == ST_IDLE && start) begin
			addr_q <= block_address;
			wr_q   <= write_access;
			cost_q <= tlc_pkg::COST_BITS'(c1_q);
		end
		if (rd_vld_s1) begin
			if (!hit_q && cur_valid[rd_idx_s1] && cur_line.tag == addr_q) begin
				hit_idx_q  <= rd_idx_s1;
				hit_line_q <= cur_line;
			end
			if (rd_idx_s1 == '0) begin
				zero_line_q <= cur_line;
				min_idx_q   <= '0;
				min_line_q  <= cur_line;
			end else if (cur_line.uses < min_line_q.uses) begin
				min_idx_q  <= rd_idx_s1;
				min_line_q <= cur_line;
			end
		end
		if (state_q == ST_DECIDE && !hit_q) begin
			vic_idx_q[lvl_q]  <= vic_idx;
			vic_line_q[lvl_q] <= vic_line;
			vic_vd_q[lvl_q]   <= vic_vd;
			cost_q <= cost_q + tlc_pkg::COST_BITS'(next_cost);
		end
	end

	assign busy = (state_q != ST_IDLE);

	tlc_stats u_stats (
		.clk(clk), .arst_n(arst_n), .commit(commit),
		.done(done), .hit_level(hit_level), .access_cost(access_cost),
		.writeback_valid(writeback_valid), .writeback_block(writeback_block),
		.total_cost(total_cost), .level_one_hits(level_one_hits),
		.level_two_hits(level_two_hits), .level_three_hits(level_three_hits),
		.memory_accesses(memory_accesses));

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");
	a_fill_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FILL |=> state_q == ST_IDLE)
		else $error("fill did not end the item");
	a_fill_l3: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FILL |-> lvl_q == tlc_pkg::LVL_L3 && !hit_q)
		else $error("fill without a full miss");

endmodule
`default_nettype wire

[design/tlc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tlc_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 8,
	parameter int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[design/tlc_stats.sv]
// Result register and saturating hit counters / running cost for the cache core.
// Depends on tlc_pkg.
`default_nettype none
module tlc_stats (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire tlc_pkg::commit_t                   commit,
	output logic                                    done,
	output logic [1:0]                              hit_level,
	output logic [tlc_pkg::COST_BITS-1:0]           access_cost,
	output logic                                    writeback_valid,
	output logic [tlc_pkg::ADDR_BITS-1:0]           writeback_block,
	output logic [tlc_pkg::CNT_BITS-1:0]            total_cost,
	output logic [tlc_pkg::CNT_BITS-1:0]            level_one_hits,
	output logic [tlc_pkg::CNT_BITS-1:0]            level_two_hits,
	output logic [tlc_pkg::CNT_BITS-1:0]            level_three_hits,
	output logic [tlc_pkg::CNT_BITS-1:0]            memory_accesses
);

	logic [tlc_pkg::CNT_BITS-1:0] cnt_q [4];
	logic [tlc_pkg::CNT_BITS-1:0] sum_q;
	logic [tlc_pkg::CNT_BITS:0]   sum_wide;
	logic                         done_q;
	logic [1:0]                   lvl_q;
	logic [tlc_pkg::COST_BITS-1:0] cost_q;
	logic                         wbv_q;
	logic [tlc_pkg::ADDR_BITS-1:0] wbb_q;

	assign sum_wide = {1'b0, sum_q} + {{(tlc_pkg::CNT_BITS + 1 - tlc_pkg::COST_BITS){1'b0}},
		commit.cost};

	// counters and total, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			sum_q  <= '0;
			for (int i = 0; i < 4; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			done_q <= commit.en;
			if (commit.en) begin
				sum_q <= sum_wide[tlc_pkg::CNT_BITS] ? '1 : sum_wide[tlc_pkg::CNT_BITS-1:0];
				if (cnt_q[commit.level] != '1) begin
					cnt_q[commit.level] <= cnt_q[commit.level] + 1'b1;
				end
			end
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (commit.en) begin
			lvl_q  <= commit.level;
			cost_q <= commit.cost;
			wbv_q  <= commit.wb_valid;
			wbb_q  <= commit.wb_valid ? commit.wb_block : '0;
		end
	end

	assign done             = done_q;
	assign hit_level        = lvl_q;
	assign access_cost      = cost_q;
	assign writeback_valid  = wbv_q;
	assign writeback_block  = wbb_q;
	assign total_cost       = sum_q;
	assign level_one_hits   = cnt_q[0];
	assign level_two_hits   = cnt_q[1];
	assign level_three_hits = cnt_q[2];
	assign memory_accesses  = cnt_q[3];

	a_wb_only_mem: assert property (@(posedge clk) disable iff (!arst_n)
		done && writeback_valid |-> hit_level == tlc_pkg::LVL_MEM)
		else $error("write-back on a non-memory item");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");
	a_commit_done: assert property (@(posedge clk) disable iff (!arst_n)
		commit.en |=> done)
		else $error("committed item not reported");

endmodule
`default_nettype wire

[sim/three_level_cache_lookup_lfu_core_tb.sv]
// Self-checking testbench for three_level_cache_lookup_lfu_core.
// Depends on tlc_pkg and the core; predicts each access with its own cache model.
`timescale 1ns / 100ps
`default_nettype none
module three_level_cache_lookup_lfu_core_tb;

	localparam logic [31:0] CNT_SAT = 32'hFFFF_FFFF;

	typedef struct {
		logic [tlc_pkg::ADDR_BITS-1:0] tag;
		bit                            valid;
		bit                            dirty;
		int unsigned                   uses;
	} cline_t;

	typedef struct {
		logic [1:0]                    level;
		logic [tlc_pkg::COST_BITS-1:0] cost;
		logic                          wbv;
		logic [tlc_pkg::ADDR_BITS-1:0] wbb;
		logic [31:0]                   tot;
		logic [31:0]                   hits [4];
	} access_res_t;

	// directed row: address, write flag, typed-in level (-1 = predictor only)
	typedef struct {
		logic [tlc_pkg::ADDR_BITS-1:0] addr;
		bit                            wr;
		int                            lvl;
	} drow_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [tlc_pkg::ADDR_BITS-1:0] block_address = '0;
	logic write_access = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	wire logic busy, done, writeback_valid, pready;
	wire logic [1:0] hit_level;
	wire logic [tlc_pkg::COST_BITS-1:0] access_cost;
	wire logic [tlc_pkg::ADDR_BITS-1:0] writeback_block;
	wire logic [31:0] total_cost, level_one_hits, level_two_hits, level_three_hits;
	wire logic [31:0] memory_accesses, prdata;

	three_level_cache_lookup_lfu_core uut (.*);

	always #5 clk = ~clk;

	// predictor state
	cline_t c1 [tlc_pkg::L1_LINES];
	cline_t c2 [tlc_pkg::L2_LINES];
	cline_t c3 [tlc_pkg::L3_LINES];
	logic [31:0] m_tot;
	logic [31:0] m_hits [4];
	bit m_lfu;
	logic [15:0] m_cost [4];

	access_res_t pending_q [$];
	int errors = 0;
	int send_idle = 0;

	function automatic logic [31:0] sat_inc(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + b;
		return s[32] ? CNT_SAT : s[31:0];
	endfunction

	function automatic int pick_victim(ref cline_t s [], input int n);
		int best;
		best = 0;
		for (int i = 0; i < n; i++)
			if (!s[i].valid) return i;
		if (m_lfu)
			for (int i = 1; i < n; i++)
				if (s[i].uses < s[best].uses) best = i;
		return best;
	endfunction

	function automatic int find_tag(ref cline_t s [], input int n, input logic [9:0] a);
		for (int i = 0; i < n; i++)
			if (s[i].valid && s[i].tag == a) return i;
		return -1;
	endfunction

	// one access through the cache model
	task automatic predict_access(input logic [9:0] a, input bit wr);
		access_res_t r;
		cline_t t1 [], t2 [], t3 [];
		int p, v1, v2, v3;
		logic [17:0] cost;
		t1 = c1; t2 = c2; t3 = c3;
		r.wbv = 0; r.wbb = '0;
		cost = m_cost[0];
		p = find_tag(t1, tlc_pkg::L1_LINES, a);
		if (p >= 0) begin
			r.level = tlc_pkg::LVL_L1;
			if (t1[p].uses < 65535) t1[p].uses++;
			if (wr) t1[p].dirty = 1;
		end else begin
			cost += m_cost[1];
			p = find_tag(t2, tlc_pkg::L2_LINES, a);
			if (p >= 0) begin
				r.level = tlc_pkg::LVL_L2;
				if (t2[p].uses < 65535) t2[p].uses++;
				if (wr) t2[p].dirty = 1;
			end else begin
				cost += m_cost[2];
				p = find_tag(t3, tlc_pkg::L3_LINES, a);
				if (p >= 0) begin
					r.level = tlc_pkg::LVL_L3;
					if (t3[p].uses < 65535) t3[p].uses++;
					if (wr) t3[p].dirty = 1;
				end else begin
					v1 = pick_victim(t1, tlc_pkg::L1_LINES);
					v2 = pick_victim(t2, tlc_pkg::L2_LINES);
					v3 = pick_victim(t3, tlc_pkg::L3_LINES);
					r.level = tlc_pkg::LVL_MEM;
					cost += m_cost[3];
					if (t1[v1].valid && t1[v1].dirty) begin
						if (t2[v2].valid && t2[v2].dirty) begin
							if (t3[v3].valid && t3[v3].dirty) begin
								r.wbv = 1;
								r.wbb = t3[v3].tag;
							end
							t3[v3] = t2[v2];
						end
						t2[v2] = t1[v1];
					end
					t1[v1] = '{a, 1'b1, wr, 1};
				end
			end
		end
		foreach (c1[i]) c1[i] = t1[i];
		foreach (c2[i]) c2[i] = t2[i];
		foreach (c3[i]) c3[i] = t3[i];
		m_hits[r.level] = sat_inc(m_hits[r.level], 1);
		m_tot = sat_inc(m_tot, cost);
		r.cost = cost;
		r.tot = m_tot;
		r.hits = m_hits;
		pending_q.push_back(r);
	endtask

	// result checker
	always @(posedge clk) begin
		access_res_t e;
		if (done) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result level %0d", $realtime, hit_level);
				errors++;
			end else begin
				e = pending_q.pop_front();
				if (hit_level !== e.level || access_cost !== e.cost ||
				    writeback_valid !== e.wbv || writeback_block !== e.wbb ||
				    total_cost !== e.tot || level_one_hits !== e.hits[0] ||
				    level_two_hits !== e.hits[1] || level_three_hits !== e.hits[2] ||
				    memory_accesses !== e.hits[3]) begin
					$display("%0t: expected lvl %0d cost %0d wb %0b/%0d tot %0d hits %0d %0d %0d %0d",
						$realtime, e.level, e.cost, e.wbv, e.wbb, e.tot,
						e.hits[0], e.hits[1], e.hits[2], e.hits[3]);
					$display("%0t: actual   lvl %0d cost %0d wb %0b/%0d tot %0d hits %0d %0d %0d %0d",
						$realtime, hit_level, access_cost, writeback_valid, writeback_block,
						total_cost, level_one_hits, level_two_hits, level_three_hits,
						memory_accesses);
					errors++;
				end
			end
		end
	end

	// register write, then read back the same register
	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		logic [31:0] exp_rd;
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		penable <= 0; pwrite <= 0;
		if (idx == tlc_pkg::REG_LFU) begin
			m_lfu = val[0];
			exp_rd = {31'b0, val[0]};
		end else begin
			m_cost[idx - 1] = val[15:0];
			exp_rd = {16'b0, val[15:0]};
		end
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		if (prdata !== exp_rd || pready !== 1'b1) begin
			$display("%0t: register %0d expected %0d, actual %0d", $realtime, idx,
				exp_rd, prdata);
			errors++;
		end
		psel <= 0; penable <= 0;
	endtask

	// drive one item, waiting for the core to take it
	task automatic send_access(input logic [9:0] a, input bit wr);
		while ($urandom_range(99) < send_idle) @(posedge clk);
		start <= 1; block_address <= a; write_access <= wr;
		do @(posedge clk); while (busy);
		predict_access(a, wr);
		start <= 0;
		@(posedge clk);
	endtask

	task automatic drain;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic set_costs(input logic [15:0] a, b, c, d, input bit lfu);
		reg_write(tlc_pkg::REG_LFU, {31'b0, lfu});
		reg_write(tlc_pkg::REG_COST1, {16'h0, a});
		reg_write(tlc_pkg::REG_COST2, {16'h0, b});
		reg_write(tlc_pkg::REG_COST3, {16'h0, c});
		reg_write(tlc_pkg::REG_COSTM, {16'h0, d});
	endtask

	drow_t dir_tab [] = '{
		'{10'd0, 1'b0, 3}, '{10'd0, 1'b0, 0}, '{10'd1023, 1'b1, 3}, '{10'd1023, 1'b0, 0},
		'{10'h155, 1'b1, 3}, '{10'h2AA, 1'b1, 3}, '{10'd5, 1'b1, 3}, '{10'd6, 1'b1, 3},
		'{10'd7, 1'b1, 3}, '{10'd8, 1'b1, 3}, '{10'd9, 1'b1, -1}, '{10'd10, 1'b1, -1},
		'{10'd11, 1'b1, -1}, '{10'd12, 1'b1, -1}, '{10'd0, 1'b0, -1}, '{10'd1023, 1'b1, -1}
	};

	initial begin
		int k, hot, ph;
		m_lfu = 1; m_cost = '{16'd1, 16'd10, 16'd100, 16'd1000};
		m_tot = 0; m_hits = '{0, 0, 0, 0};
		foreach (c1[i]) c1[i] = '{'0, 0, 0, 0};
		foreach (c2[i]) c2[i] = '{'0, 0, 0, 0};
		foreach (c3[i]) c3[i] = '{'0, 0, 0, 0};
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed table; cost 1111 on a miss and 1 on an L1 hit at reset values
		foreach (dir_tab[i]) begin
			send_access(dir_tab[i].addr, dir_tab[i].wr);
			if (dir_tab[i].lvl >= 0 && pending_q[$].level != dir_tab[i].lvl) begin
				$display("%0t: table row %0d expected level %0d, model %0d",
					$realtime, i, dir_tab[i].lvl, pending_q[$].level);
				errors++;
			end
		end
		drain();
		set_costs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		for (int i = 0; i < 60; i++) send_access(i[9:0] * 10'd17, 1'b1);
		// random phases with varying settings and idling
		for (ph = 0; ph < 6; ph++) begin
			drain();
			case (ph)
				0: set_costs(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
				1: set_costs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					1'b0);
				2: set_costs(16'd1, 16'd10, 16'd100, 16'd1000, 1'b1);
				3: set_costs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					1'b1);
				4: set_costs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
				default: set_costs(16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 1'($urandom_range(1)));
			endcase
			send_idle = (ph % 3 == 0) ? 0 : (ph % 3 == 1 ? 59 : 28);
			hot = $urandom_range(1023);
			for (k = 0; k < 215; k++) begin
				// mostly a working set near 61 blocks, some wide-range noise
				if ($urandom_range(9) < 8)
					send_access(10'(hot + $urandom_range(60)), 1'($urandom_range(1)));
				else
					send_access(10'($urandom), 1'($urandom_range(1)));
			end
		end
		while (pending_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire
